>>> hw/rtl/spq_pkg.sv
// shared types and constants for the stable priority queue
// no dependencies; imported by the interfaces, the cell and the top level
package spq_pkg;

  localparam int SPQ_DEPTH       = 16;
  localparam int SPQ_ID_BITS     = 16;
  localparam int SPQ_PRIO_BITS   = 4;
  localparam int SPQ_CNT_BITS    = $clog2(SPQ_DEPTH + 1);
  localparam int SPQ_PORT_ID_BITS = 16;
  localparam int SPQ_OCC_BITS    = 5;
  localparam int SPQ_STATUS_BITS = 3;

  localparam logic [SPQ_PRIO_BITS-1:0] SPQ_RESET_MAX_PRIO = SPQ_PRIO_BITS'(10);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } spq_op_t;

  typedef enum logic [SPQ_STATUS_BITS-1:0] {
    ST_ENQ   = 3'd0,
    ST_DEQ   = 3'd1,
    ST_RANGE = 3'd2,
    ST_EMPTY = 3'd3,
    ST_FULL  = 3'd4
  } spq_status_t;

  typedef struct packed {
    logic [SPQ_ID_BITS-1:0]   id;
    logic [SPQ_PRIO_BITS-1:0] prio;
  } spq_entry_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic       ins;
    logic       pop;
    spq_entry_t item;
  } spq_ctrl_t;

endpackage

>>> hw/rtl/spq_if.sv
// valid/ready channel interfaces of the stable priority queue
// depends on spq_pkg for field widths
interface spq_in_if;
  import spq_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [SPQ_PORT_ID_BITS-1:0] task_id;
  logic [SPQ_PRIO_BITS-1:0]    prio;
  modport source (output valid, output op, output task_id, output prio, input ready);
  modport sink   (input valid, input op, input task_id, input prio, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [SPQ_STATUS_BITS-1:0]  status;
  logic [SPQ_PORT_ID_BITS-1:0] out_id;
  logic [SPQ_OCC_BITS-1:0]     occupancy;
  modport source (output valid, output status, output out_id, output occupancy, input ready);
  modport sink   (input valid, input status, input out_id, input occupancy, output ready);
endinterface

interface spq_cfg_if;
  import spq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [SPQ_PRIO_BITS-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/stable_priority_queue.sv
// top level of the stable priority queue: control, count and output register
// depends on spq_pkg, spq_if and spq_cell
//
// Bounded priority queue of SPQ_DEPTH task ids, each with a 4-bit priority.
// Entries live in a row of cells kept sorted by priority, highest at cell 0,
// with equal priorities in arrival order. An enqueue is compared against every
// cell at once; each cell then keeps its entry, takes the new one, or takes its
// left neighbor's, so the row stays sorted after every enqueue. A dequeue returns
// cell 0 and shifts the row left by one. Every item gives exactly one result
// (status, removed id, occupancy after the item). The cell row updates as each
// item is taken; the result sits in an output register, and a new item is taken
// whenever that register is empty or being drained, so the queue sustains one
// item per clock while results are taken. An enqueue with a priority above
// max_priority gives status 2 before the full check (status 4); a dequeue on
// an empty queue gives status 3. max_priority is written through the cfg
// channel, which is always ready; it resets to 10. No clearing pass is needed
// after reset.
module stable_priority_queue import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch,
  spq_cfg_if.sink   cfg_ch
);

  logic [SPQ_PRIO_BITS-1:0]    max_prio_r;
  logic [SPQ_CNT_BITS-1:0]     count_r, count_nxt;
  logic                        out_valid_r;
  spq_status_t                 out_status_r, status_nxt;
  logic [SPQ_PORT_ID_BITS-1:0] out_id_r, out_id_nxt;
  logic [SPQ_OCC_BITS-1:0]     out_occ_r;

  logic       in_accept;
  logic       is_deq;
  logic       is_empty, is_full, range_err;
  spq_ctrl_t  ctrl;

  spq_entry_t             cell_q [SPQ_DEPTH];
  logic [SPQ_DEPTH-1:0]   keep_vec;
  logic [SPQ_DEPTH-1:0]   occ_vec;

  // handshakes
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_id    = out_id_r;
  assign out_ch.occupancy = out_occ_r;

  // item decode
  assign is_deq    = (spq_op_t'(in_ch.op) == OP_DEQ);
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == SPQ_CNT_BITS'(SPQ_DEPTH));
  assign range_err = (in_ch.prio > max_prio_r);

  always_comb begin
    ctrl.ins       = 1'b0;
    ctrl.pop       = 1'b0;
    ctrl.item.id   = SPQ_ID_BITS'(in_ch.task_id);
    ctrl.item.prio = in_ch.prio;
    count_nxt      = count_r;
    out_id_nxt     = '0;
    if (is_deq) begin
      if (is_empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_DEQ;
        ctrl.pop   = in_accept;
        count_nxt  = count_r - SPQ_CNT_BITS'(1);
        out_id_nxt = SPQ_PORT_ID_BITS'(cell_q[0].id);
      end
    end else if (range_err) begin
      status_nxt = ST_RANGE;
    end else if (is_full) begin
      status_nxt = ST_FULL;
    end else begin
      status_nxt = ST_ENQ;
      ctrl.ins   = in_accept;
      count_nxt  = count_r + SPQ_CNT_BITS'(1);
    end
  end

  // row of cells, cell 0 holds the next entry to leave
  for (genvar i = 0; i < SPQ_DEPTH; i++) begin : g_cell
    spq_entry_t left_e, right_e;
    logic       left_k;

    assign occ_vec[i] = (SPQ_CNT_BITS'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_k = 1'b1;
      assign left_e = ctrl.item;
    end else begin : g_mid
      assign left_k = keep_vec[i-1];
      assign left_e = cell_q[i-1];
    end

    if (i == SPQ_DEPTH - 1) begin : g_last
      assign right_e = cell_q[i];
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ_vec[i]),
      .left_keep   (left_k),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (cell_q[i]),
      .keep        (keep_vec[i])
    );
  end

  // count, config and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_prio_r  <= SPQ_RESET_MAX_PRIO;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        max_prio_r <= cfg_ch.data;
      end
      if (in_accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_status_r <= status_nxt;
      out_id_r     <= out_id_nxt;
      out_occ_r    <= SPQ_OCC_BITS'(count_nxt);
    end
  end

  // row stays sorted at the head
  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= SPQ_CNT_BITS'(2)) |-> (cell_q[0].prio >= cell_q[1].prio))
    else $error("head of entry row out of priority order");

  // count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SPQ_CNT_BITS'(SPQ_DEPTH))
    else $error("entry count above depth");

  // a successful dequeue shrinks the count by one
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && is_deq && !is_empty) |=>
      (count_r == $past(count_r) - SPQ_CNT_BITS'(1)))
    else $error("dequeue did not decrement count");

  // dequeue on empty reports empty with no id
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && is_deq && is_empty) |=>
      (out_valid_r && out_status_r == ST_EMPTY && out_id_r == '0))
    else $error("empty dequeue result wrong");

endmodule

>>> hw/rtl/spq_cell.sv
// one slot of the sorted entry row: holds, takes the new item or shifts
// depends on spq_pkg
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  spq_ctrl_t  ctrl,
  input  logic       occ,         // this slot holds a live entry
  input  logic       left_keep,   // left neighbor keeps its entry on insert
  input  spq_entry_t left_entry,
  input  spq_entry_t right_entry,
  output spq_entry_t entry,
  output logic       keep
);

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;

  // equal priorities stay ahead of the newcomer, which keeps the order stable
  assign keep  = occ && (entry_r.prio >= ctrl.item.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.pop) begin
      entry_nxt = right_entry;
    end else if (ctrl.ins && !keep) begin
      entry_nxt = left_keep ? ctrl.item : left_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
